// File: hw/rtl/vcsm_pkg.sv
// ----------------------------------------------------------------------------
// vcsm_pkg
// Types and codes shared by the velocity command safety mux and its checker.
// ----------------------------------------------------------------------------
package vcsm_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] CFG_LIMIT_X      = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_LIMIT_Y      = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_LIMIT_YAW    = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_LINEAR_STEP  = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_ANGULAR_STEP = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_TIMEOUT      = 3'd5;
  localparam logic [CfgAddrW-1:0] CFG_MANUAL_FIRST = 3'd6;

  localparam logic [14:0] RST_LIMIT_X      = 15'd1638;
  localparam logic [14:0] RST_LIMIT_Y      = 15'd819;
  localparam logic [14:0] RST_LIMIT_YAW    = 15'd2048;
  localparam logic [14:0] RST_LINEAR_STEP  = 15'd164;
  localparam logic [14:0] RST_ANGULAR_STEP = 15'd205;
  localparam logic [15:0] RST_TIMEOUT      = 16'd10;
  localparam logic        RST_MANUAL_FIRST = 1'b1;

  localparam logic [15:0] AGE_MAX = 16'hFFFF;

  localparam logic [1:0] REQ_NAV    = 2'd0;
  localparam logic [1:0] REQ_MANUAL = 2'd1;
  localparam logic [1:0] REQ_ESTOP  = 2'd2;
  localparam logic [1:0] REQ_TICK   = 2'd3;

  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_NAV    = 2'd1;
  localparam logic [1:0] SRC_MANUAL = 2'd2;
  localparam logic [1:0] SRC_ESTOP  = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
    logic               stop_request;
  } vcsm_in_t;

  typedef struct packed {
    logic signed [15:0] out_vel_x;
    logic signed [15:0] out_vel_y;
    logic signed [15:0] out_yaw_rate;
    logic [1:0]         source;
  } vcsm_out_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] yaw;
  } vcsm_vec_t;

endpackage

// File: hw/rtl/velocity_command_safety_mux.sv
// ----------------------------------------------------------------------------
// velocity_command_safety_mux
// Twist mux with e-stop, per-axis clamp and slew limiting of the output.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one item per handshake; navigation command, manual command,
//            e-stop level update or publish tick (req_type).
//   out_*  : one item per publish tick: safe x, y, yaw rate and the source.
//   cfg_*  : plain register writes, only while no item is in flight.
// Path: an accepted item is held in the input register; a tick's result
//   then goes into the output register and shows on out_* once no earlier
//   result is waiting there.
// Throughput: one item per cycle unless a tick waits on a stalled result;
//   per-axis clamp and slew adders sit between input and output registers.
// Stall: while out_stall holds a result, commands and e-stop updates still
//   drain; a tick waits in the input register and in_stall rises.
// Reset: sources unseen, e-stop off, last output zero, registers at their
//   reset values, both registers empty.
// ----------------------------------------------------------------------------
module velocity_command_safety_mux (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  vcsm_pkg::vcsm_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output vcsm_pkg::vcsm_out_t         out_data,
  input  logic                        cfg_we,
  input  logic [vcsm_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [vcsm_pkg::CfgDataW-1:0] cfg_wdata
);
  import vcsm_pkg::*;

  logic [14:0] limit_x_r, limit_y_r, limit_yaw_r, lin_step_r, ang_step_r;
  logic [15:0] timeout_r;
  logic        manual_first_r;

  vcsm_in_t  s1_r;
  logic      s1_valid_r, s1_valid_nxt;
  vcsm_out_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  vcsm_vec_t   nav_cmd_r, man_cmd_r, last_r;
  logic [15:0] nav_age_r, man_age_r;
  logic        nav_seen_r, man_seen_r, stop_r;

  logic      s1_tick, s1_go, out_free, in_take, do_tick;
  logic      nav_live, man_live;
  logic [1:0] src;
  vcsm_vec_t  target, result;

  function automatic logic signed [15:0] clamp_sym(logic signed [15:0] v,
                                                   logic [14:0] lim);
    logic signed [16:0] v17;
    logic signed [16:0] l17;
    logic signed [16:0] r17;
    v17 = {v[15], v};
    l17 = {2'b00, lim};
    if (v17 > l17) r17 = l17;
    else if (v17 < -l17) r17 = -l17;
    else r17 = v17;
    return r17[15:0];
  endfunction

  function automatic logic signed [15:0] slew(logic signed [15:0] cur,
                                              logic signed [15:0] tgt,
                                              logic [14:0] step);
    logic signed [17:0] d;
    logic signed [17:0] s;
    logic signed [17:0] r;
    d = {{2{tgt[15]}}, tgt} - {{2{cur[15]}}, cur};
    s = {3'b000, step};
    if (d > s) d = s;
    else if (d < -s) d = -s;
    r = {{2{cur[15]}}, cur} + d;
    if (step == 15'd0) return tgt;
    return r[15:0];
  endfunction

  assign s1_tick  = (s1_r.req_type == REQ_TICK);
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_tick || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;
  assign do_tick  = s1_go && s1_tick;

  assign nav_live = nav_seen_r && (nav_age_r <= timeout_r);
  assign man_live = man_seen_r && (man_age_r <= timeout_r);

  always_comb begin
    if (stop_r) src = SRC_ESTOP;
    else if (manual_first_r) begin
      if (man_live) src = SRC_MANUAL;
      else if (nav_live) src = SRC_NAV;
      else src = SRC_NONE;
    end else begin
      if (nav_live) src = SRC_NAV;
      else if (man_live) src = SRC_MANUAL;
      else src = SRC_NONE;
    end
  end

  always_comb begin
    case (src)
      SRC_NAV:    target = nav_cmd_r;
      SRC_MANUAL: target = man_cmd_r;
      default:    target = '0;
    endcase
    result.x   = slew(last_r.x, clamp_sym(target.x, limit_x_r), lin_step_r);
    result.y   = slew(last_r.y, clamp_sym(target.y, limit_y_r), lin_step_r);
    result.yaw = slew(last_r.yaw, clamp_sym(target.yaw, limit_yaw_r), ang_step_r);
    out_nxt.out_vel_x    = result.x;
    out_nxt.out_vel_y    = result.y;
    out_nxt.out_yaw_rate = result.yaw;
    out_nxt.source       = src;
  end

  always_comb begin
    if (in_take) s1_valid_nxt = 1'b1;
    else if (s1_go) s1_valid_nxt = 1'b0;
    else s1_valid_nxt = s1_valid_r;
    if (do_tick) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_x_r      <= RST_LIMIT_X;
      limit_y_r      <= RST_LIMIT_Y;
      limit_yaw_r    <= RST_LIMIT_YAW;
      lin_step_r     <= RST_LINEAR_STEP;
      ang_step_r     <= RST_ANGULAR_STEP;
      timeout_r      <= RST_TIMEOUT;
      manual_first_r <= RST_MANUAL_FIRST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LIMIT_X:      limit_x_r      <= cfg_wdata[14:0];
        CFG_LIMIT_Y:      limit_y_r      <= cfg_wdata[14:0];
        CFG_LIMIT_YAW:    limit_yaw_r    <= cfg_wdata[14:0];
        CFG_LINEAR_STEP:  lin_step_r     <= cfg_wdata[14:0];
        CFG_ANGULAR_STEP: ang_step_r     <= cfg_wdata[14:0];
        CFG_TIMEOUT:      timeout_r      <= cfg_wdata;
        CFG_MANUAL_FIRST: manual_first_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_r <= in_data;
    if (do_tick) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      nav_cmd_r   <= '0;
      man_cmd_r   <= '0;
      last_r      <= '0;
      nav_age_r   <= '0;
      man_age_r   <= '0;
      nav_seen_r  <= 1'b0;
      man_seen_r  <= 1'b0;
      stop_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        case (s1_r.req_type)
          REQ_NAV: begin
            nav_cmd_r  <= '{x: s1_r.vel_x, y: s1_r.vel_y, yaw: s1_r.yaw_rate};
            nav_age_r  <= '0;
            nav_seen_r <= 1'b1;
          end
          REQ_MANUAL: begin
            man_cmd_r  <= '{x: s1_r.vel_x, y: s1_r.vel_y, yaw: s1_r.yaw_rate};
            man_age_r  <= '0;
            man_seen_r <= 1'b1;
          end
          REQ_ESTOP: stop_r <= s1_r.stop_request;
          default: begin
            last_r <= result;
            if (nav_age_r != AGE_MAX) nav_age_r <= nav_age_r + 16'd1;
            if (man_age_r != AGE_MAX) man_age_r <= man_age_r + 16'd1;
          end
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/vcsm_checker.sv
// ----------------------------------------------------------------------------
// vcsm_port_props
// Port-level assertions for the velocity command safety mux, bound to it.
// ----------------------------------------------------------------------------
module vcsm_port_props (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_stall,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  vcsm_pkg::vcsm_out_t         out_data
);
  import vcsm_pkg::*;

  logic signed [15:0] prev_x_r;
  logic        [16:0] mag_x, mag_prev;
  logic               ramp_down;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
    end else if (out_valid && !out_stall) begin
      prev_x_r <= out_data.out_vel_x;
    end
  end

  assign mag_x = out_data.out_vel_x[15] ? 17'(-{out_data.out_vel_x[15], out_data.out_vel_x})
                                        : {1'b0, out_data.out_vel_x};
  assign mag_prev = prev_x_r[15] ? 17'(-{prev_x_r[15], prev_x_r}) : {1'b0, prev_x_r};
  assign ramp_down = (out_data.source == SRC_ESTOP) || (out_data.source == SRC_NONE);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_stall_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  a_ramp_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ramp_down) |-> (mag_x <= mag_prev))
    else $error("forward speed grew with no active source");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind velocity_command_safety_mux vcsm_port_props u_vcsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
